// File: rtl/strip_fan_triangle_assembler_unit_defines.svh
// Assertion macros used by the output stage of the strip and fan triangle assembler RTL.
`ifndef STRIP_FAN_TRIANGLE_ASSEMBLER_UNIT_DEFINES_SVH
`define STRIP_FAN_TRIANGLE_ASSEMBLER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SFTA_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define SFTA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/sfta_pkg.sv
// Shared types for the strip and fan triangle assembler.
package sfta_pkg;

  // One vertex: vertex index, normal index, s, t from low to high.
  typedef logic [63:0] vtx_t;

  // Triangle handed from the assembler to the output stage.
  typedef struct packed {
    logic load;
    vtx_t c2;
    vtx_t c1;
    vtx_t c0;
  } tri_set_t;

  localparam logic [1:0] LastWordPos = 2'd3;
  localparam logic [1:0] LastCorner  = 2'd2;

endpackage

// File: rtl/sfta_asm.sv
// Run decoder and vertex store that forms one triangle per new vertex.
module sfta_asm (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic signed [15:0] word,
  output logic               emit_due,
  output sfta_pkg::tri_set_t tri_out
);
  import sfta_pkg::*;

  logic        await_header;
  logic        fan_mode;
  logic        strip_flip;
  logic [15:0] tris_left;
  logic [1:0]  word_pos;
  logic [1:0]  verts_loaded;
  vtx_t        slots [3];

  logic [15:0] word_u;
  logic [1:0]  slot_sel;
  vtx_t        newest;
  logic        flip_next;
  logic [16:0] mag;
  logic [15:0] tris_init;

  // Decode of the current word against the run state.
  always_comb begin
    word_u    = word;
    slot_sel  = (verts_loaded == 2'd3) ? 2'd2 : verts_loaded;
    newest    = {word_u, slots[2][47:0]};
    emit_due  = !await_header && (word_pos == LastWordPos) &&
                (verts_loaded >= 2'd2) && (tris_left != 16'd0);
    flip_next = !strip_flip;
    mag       = word_u[15] ? (17'h10000 - {1'b0, word_u}) : {1'b0, word_u};
    tris_init = (mag > 17'd2) ? 16'(mag - 17'd2) : 16'd0;
  end

  // Triangle corners in the order the run type asks for.
  always_comb begin
    tri_out.load = in_fire && emit_due;
    if (fan_mode) begin
      tri_out.c0 = slots[0];
      tri_out.c1 = newest;
      tri_out.c2 = slots[1];
    end else begin
      tri_out.c0 = flip_next ? slots[1] : slots[0];
      tri_out.c1 = flip_next ? slots[0] : slots[1];
      tri_out.c2 = newest;
    end
  end

  // Run control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      await_header <= 1'b1;
      fan_mode     <= 1'b0;
      strip_flip   <= 1'b0;
      tris_left    <= 16'd0;
      word_pos     <= 2'd0;
      verts_loaded <= 2'd0;
    end else if (in_fire) begin
      if (await_header) begin
        if (word_u != 16'd0) begin
          fan_mode     <= word_u[15];
          tris_left    <= tris_init;
          strip_flip   <= 1'b0;
          word_pos     <= 2'd0;
          verts_loaded <= 2'd0;
          await_header <= 1'b0;
        end
      end else if (word_pos != LastWordPos) begin
        word_pos <= word_pos + 2'd1;
      end else begin
        word_pos <= 2'd0;
        if (verts_loaded != 2'd3) begin
          verts_loaded <= verts_loaded + 2'd1;
        end
        if (verts_loaded >= 2'd2) begin
          if (tris_left == 16'd0) begin
            await_header <= 1'b1;
          end else begin
            tris_left <= tris_left - 16'd1;
            if (tris_left == 16'd1) begin
              await_header <= 1'b1;
            end
            if (!fan_mode) begin
              strip_flip <= flip_next;
            end
          end
        end
      end
    end
  end

  // Vertex store: field writes, and the slot shift when a triangle goes out.
  always_ff @(posedge clk) begin
    if (in_fire && !await_header) begin
      if (emit_due) begin
        if (fan_mode) begin
          slots[1] <= newest;
          slots[2] <= newest;
        end else begin
          slots[0] <= slots[1];
          slots[1] <= newest;
          slots[2] <= newest;
        end
      end else begin
        slots[slot_sel][16 * word_pos +: 16] <= word_u;
      end
    end
  end

endmodule

// File: rtl/sfta_out.sv
// Triangle buffer that hands out the three corners one transaction at a time.
module sfta_out (
  input  logic               clk,
  input  logic               rst,
  input  sfta_pkg::tri_set_t tri_in,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] vert_index,
  output logic signed [15:0] norm_index,
  output logic signed [15:0] tex_s,
  output logic signed [15:0] tex_t,
  output logic [1:0]         corner,
  output logic               tri_last
);
  import sfta_pkg::*;
  `include "strip_fan_triangle_assembler_unit_defines.svh"

  vtx_t       held [3];
  logic [1:0] cnt;
  vtx_t       sel;
  logic       out_fire;

  // Corner select and output fields.
  always_comb begin
    case (cnt)
      2'd0:    sel = held[0];
      2'd1:    sel = held[1];
      default: sel = held[2];
    endcase
    out_fire   = busy && out_ready;
    out_valid  = busy;
    vert_index = signed'(sel[15:0]);
    norm_index = signed'(sel[31:16]);
    tex_s      = signed'(sel[47:32]);
    tex_t      = signed'(sel[63:48]);
    corner     = cnt;
    tri_last   = (cnt == LastCorner);
  end

  // Buffer occupancy and corner counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 2'd0;
    end else if (tri_in.load) begin
      busy <= 1'b1;
      cnt  <= 2'd0;
    end else if (out_fire) begin
      if (cnt == LastCorner) begin
        busy <= 1'b0;
        cnt  <= 2'd0;
      end else begin
        cnt <= cnt + 2'd1;
      end
    end
  end

  // Triangle payload.
  always_ff @(posedge clk) begin
    if (tri_in.load) begin
      held[0] <= tri_in.c0;
      held[1] <= tri_in.c1;
      held[2] <= tri_in.c2;
    end
  end

  `SFTA_ASSERT_NOW(a_no_overwrite, clk, rst, tri_in.load, !busy, "triangle loaded into a busy buffer")
  `SFTA_ASSERT_NOW(a_corner_range, clk, rst, busy, cnt != 2'd3, "corner counter out of range")
  `SFTA_ASSERT_NEXT(a_drain_done, clk, rst, out_fire && tri_last && !tri_in.load, !busy, "buffer still busy after last corner")

endmodule

// File: rtl/strip_fan_triangle_assembler_unit.sv
// Top level of the strip and fan triangle assembler.
// A triangle's first corner is valid in the cycle after its last vertex word is taken.
// Throughput: one command word per cycle; each triangle then drains its three corners through the output handshake.
// A word that completes a triangle waits only while the previous triangle is still draining.
// Reset (rst, synchronous, active high) returns to waiting for a run header; the buffer empties.
module strip_fan_triangle_assembler_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] vert_index,
  output logic signed [15:0] norm_index,
  output logic signed [15:0] tex_s,
  output logic signed [15:0] tex_t,
  output logic [1:0]         corner,
  output logic               tri_last
);
  import sfta_pkg::*;

  tri_set_t tri_set;
  logic     emit_due;
  logic     busy;
  logic     in_fire;

  // Hold off only a word that would complete a triangle while one still drains.
  assign in_ready = !(busy && emit_due);
  assign in_fire  = in_valid && in_ready;

  sfta_asm u_asm (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .word     (word),
    .emit_due (emit_due),
    .tri_out  (tri_set)
  );

  sfta_out u_out (
    .clk        (clk),
    .rst        (rst),
    .tri_in     (tri_set),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .vert_index (vert_index),
    .norm_index (norm_index),
    .tex_s      (tex_s),
    .tex_t      (tex_t),
    .corner     (corner),
    .tri_last   (tri_last)
  );

endmodule
